[src/uartrb_pkg.sv]
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and constants for the received-byte ring buffer.
// ----------------------------------------------------------------------------
package uartrb_pkg;

    // Default sizes for the top level parameters
    localparam int DEPTH_DEF     = 128;
    localparam int MAX_BURST_DEF = 64;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int RCNT_W  = 7;
    localparam int FILL_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Register map (word index taken from paddr[2])
    localparam logic REG_BREAK_CHAR = 1'b0;
    localparam logic [BYTE_W-1:0] BREAK_CHAR_RST = 8'd17;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_code;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the input word this cycle
        logic emit;     // move one buffered byte to the output register
    } t_ctrl;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can load this cycle
        logic read_start;  // input word is a read that returns buffered bytes
        logic last_byte;   // one byte left in the current read
    } t_stat;

endpackage

[src/uartrb_ctrl.sv]
// ----------------------------------------------------------------------------
// uartrb_ctrl
// Controller: sequences input acceptance and the byte-by-byte read burst.
// ----------------------------------------------------------------------------
module uartrb_ctrl
    import uartrb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_ctrl.accept = 1'b0;
        o_ctrl.emit   = 1'b0;
        o_stall       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall       = !i_stat.out_free;
                o_ctrl.accept = i_valid && i_stat.out_free;
                if (o_ctrl.accept && i_stat.read_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_ctrl.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.last_byte) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/uartrb_dp.sv]
// ----------------------------------------------------------------------------
// uartrb_dp
// Datapath: byte store, pointers, fill count, break check, output register.
// ----------------------------------------------------------------------------
module uartrb_dp
    import uartrb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    output t_stat             o_stat,
    input  logic [BYTE_W-1:0] i_break_char,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [RCNT_W-1:0] i_read_count,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_data_valid,
    output logic              o_last,
    output logic              o_accepted,
    output logic              o_break_seen,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > RCNT_W) ? CW : RCNT_W;
    localparam logic [RCNT_W-1:0] MAXB = RCNT_W'(MAX_BURST);
    localparam logic [AW-1:0] PTR_TOP = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // Byte store
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Control state
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_last_stored, n_last_stored;
    logic [RCNT_W-1:0] r_remain, n_remain;
    logic              r_out_valid, n_out_valid;

    // Output payload
    logic [BYTE_W-1:0] r_data_byte, n_data_byte;
    logic              r_data_valid, n_data_valid;
    logic              r_last, n_last;
    logic              r_accepted, n_accepted;
    logic              r_break_seen, n_break_seen;
    logic [FILL_W-1:0] r_fill_level;

    logic              mem_we;
    logic              out_load;
    logic [AW-1:0]     wr_next, rd_next;
    logic [RCNT_W-1:0] want;
    logic [WW-1:0]     want_w, count_w, take_w;
    logic [RCNT_W-1:0] take;
    logic              is_full;
    logic [CW+FILL_W-1:0] fill_ext;

    // Pointer advance with wrap
    assign wr_next = (r_wr_ptr == PTR_TOP) ? '0 : r_wr_ptr + AW'(1);
    assign rd_next = (r_rd_ptr == PTR_TOP) ? '0 : r_rd_ptr + AW'(1);
    assign is_full = (r_count == CNT_FULL);

    // Clamp read length to the burst limit and to the fill level
    assign want    = (i_read_count > MAXB) ? MAXB : i_read_count;
    assign want_w  = WW'(want);
    assign count_w = WW'(r_count);
    assign take_w  = (want_w > count_w) ? count_w : want_w;
    assign take    = take_w[RCNT_W-1:0];

    assign o_stat.out_free   = !r_out_valid || !i_stall;
    assign o_stat.read_start = (t_cmd_code'(i_command) == CMD_READ) && (take != '0);
    assign o_stat.last_byte  = (r_remain == RCNT_W'(1));

    // Next state of pointers, count and output word
    always_comb begin
        n_wr_ptr      = r_wr_ptr;
        n_rd_ptr      = r_rd_ptr;
        n_count       = r_count;
        n_last_stored = r_last_stored;
        n_remain      = r_remain;
        mem_we        = 1'b0;
        out_load      = 1'b0;
        n_data_byte   = '0;
        n_data_valid  = 1'b0;
        n_last        = 1'b1;
        n_accepted    = 1'b0;
        n_break_seen  = 1'b0;
        if (i_ctrl.accept) begin
            unique case (t_cmd_code'(i_command))
                CMD_PUSH: begin
                    out_load     = 1'b1;
                    n_break_seen = (r_last_stored == i_break_char) &&
                                   (i_rx_byte == i_break_char);
                    if (!is_full) begin
                        mem_we        = 1'b1;
                        n_wr_ptr      = wr_next;
                        n_count       = r_count + CW'(1);
                        n_last_stored = i_rx_byte;
                        n_accepted    = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (take == '0) begin
                        out_load = 1'b1;
                    end else begin
                        n_remain = take;
                    end
                end
                CMD_CLEAR: begin
                    out_load = 1'b1;
                    n_wr_ptr = '0;
                    n_rd_ptr = '0;
                    n_count  = '0;
                end
                CMD_NOP: begin
                    out_load = 1'b1;
                end
                default: begin
                    out_load = 1'b1;
                end
            endcase
        end else if (i_ctrl.emit) begin
            out_load     = 1'b1;
            n_data_byte  = r_rdata;
            n_data_valid = 1'b1;
            n_last       = (r_remain == RCNT_W'(1));
            n_rd_ptr     = rd_next;
            n_count      = r_count - CW'(1);
            n_remain     = r_remain - RCNT_W'(1);
        end
        n_out_valid = out_load || (r_out_valid && i_stall);
    end

    // Fill level reports the low bits of the count after this word
    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
            r_last_stored <= '0;
            r_remain      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_wr_ptr      <= n_wr_ptr;
            r_rd_ptr      <= n_rd_ptr;
            r_count       <= n_count;
            r_last_stored <= n_last_stored;
            r_remain      <= n_remain;
            r_out_valid   <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_data_byte  <= n_data_byte;
            r_data_valid <= n_data_valid;
            r_last       <= n_last;
            r_accepted   <= n_accepted;
            r_break_seen <= n_break_seen;
            r_fill_level <= fill_ext[FILL_W-1:0];
        end
    end

    // Store write; read follows the next read pointer so the read data is registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
        r_rdata <= r_mem[n_rd_ptr];
    end

    assign o_valid      = r_out_valid;
    assign o_data_byte  = r_data_byte;
    assign o_data_valid = r_data_valid;
    assign o_last       = r_last;
    assign o_accepted   = r_accepted;
    assign o_break_seen = r_break_seen;
    assign o_fill_level = r_fill_level;

    // Count never passes the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count above depth");

    // A byte is only emitted from a non-empty buffer within an open burst
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> (r_count != '0) && (r_remain != '0))
        else $error("emit with empty buffer or no burst");

    // A push into a non-full buffer raises the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.accept && (t_cmd_code'(i_command) == CMD_PUSH) && !is_full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not advance count");

    // Accept and emit never coincide
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.accept && i_ctrl.emit))
        else $error("accept and emit in the same cycle");

endmodule

[src/uart_rx_ring_with_break_detect_unit.sv]
// ----------------------------------------------------------------------------
// uart_rx_ring_with_break_detect_unit
// Received-byte ring buffer with push, burst read and clear commands and a
// double break-character detector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command word: push of
//   i_rx_byte, read of up to i_read_count bytes, clear or no-op. The output
//   channel (o_valid / i_stall) returns result words from a single output
//   register; o_last marks the final word of each command.
//   Push, clear and empty reads produce one word, ready the cycle after the
//   command is taken; a new command can be taken every cycle as long as the
//   output register drains.
//   A read of N bytes produces N words at one per cycle while the output
//   register drains, read from the registered store once the controller is
//   in its read state; the byte store's single read port sets the rate. No
//   command is taken until the burst's last word is in the output register.
//   When the receiver stalls, the output word holds and the input stalls
//   once the output register is full.
//   Reset empties the buffer, clears the last stored byte and sets the
//   break character to 17. The store contents are not cleared.
//   The break character is written over the APB port at address 0.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_break_detect_unit
    import uartrb_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [RCNT_W-1:0] i_read_count,
    // Result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_data_valid,
    output logic              o_last,
    output logic              o_accepted,
    output logic              o_break_seen,
    output logic [FILL_W-1:0] o_fill_level,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] r_break_char;
    logic              cfg_wr;
    t_ctrl             ctrl;
    t_stat             stat;

    // Register write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BREAK_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_char <= BREAK_CHAR_RST;
        end else if (cfg_wr) begin
            r_break_char <= pwdata[BYTE_W-1:0];
        end
    end

    // Register read
    assign prdata = (paddr[2] == REG_BREAK_CHAR) ?
                    {{(APB_DW-BYTE_W){1'b0}}, r_break_char} : '0;

    uartrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    uartrb_dp #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_break_char (r_break_char),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_read_count (i_read_count),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_data_byte  (o_data_byte),
        .o_data_valid (o_data_valid),
        .o_last       (o_last),
        .o_accepted   (o_accepted),
        .o_break_seen (o_break_seen),
        .o_fill_level (o_fill_level)
    );

endmodule

[bench/tb_uart_rx_ring_with_break_detect_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_ring_with_break_detect_unit
// Self-checking bench for the received-byte ring buffer. A behavioral copy of
// the ring, its pointers, the last stored byte and the break character
// predicts every result word. Directed cases come first: break detection,
// read limits, clear, the extreme break characters and a full buffer. Random
// traffic follows, with random gaps on both channels, then with none.
// ----------------------------------------------------------------------------
module tb_uart_rx_ring_with_break_detect_unit;
    import uartrb_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int MAX_BURST = MAX_BURST_DEF;

    // One result word as the block presents it
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic              is_last;
        logic              accepted;
        logic              break_seen;
        logic [FILL_W-1:0] fill;
    } t_result_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command;
    logic [BYTE_W-1:0] i_rx_byte;
    logic [RCNT_W-1:0] i_read_count;
    logic              o_valid;
    logic              i_stall;
    logic [BYTE_W-1:0] o_data_byte;
    logic              o_data_valid;
    logic              o_last;
    logic              o_accepted;
    logic              o_break_seen;
    logic [FILL_W-1:0] o_fill_level;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Ring buffer model
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    int                ring_wr_ptr;
    int                ring_rd_ptr;
    int                ring_count;
    logic [BYTE_W-1:0] ring_last_stored;
    logic [BYTE_W-1:0] ring_break_char;

    t_result_word      pending_results [$];
    int                mismatch_count;
    bit                tx_quiet;
    bit                rx_quiet;
    int                rx_run_left;
    bit                rx_holding;
    int                rx_run;
    t_result_word      got_word;
    t_result_word      want_word;

    uart_rx_ring_with_break_detect_unit #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_read_count (i_read_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_byte  (o_data_byte),
        .o_data_valid (o_data_valid),
        .o_last       (o_last),
        .o_accepted   (o_accepted),
        .o_break_seen (o_break_seen),
        .o_fill_level (o_fill_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    always #1 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor the break character so double breaks happen often
    function automatic logic [BYTE_W-1:0] pick_rx_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return ring_break_char;
        if (r < 40) return 8'h00;
        if (r < 45) return 8'hff;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [RCNT_W-1:0] pick_read_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 55) return RCNT_W'($urandom_range(1, 8));
        if (r < 70) return RCNT_W'($urandom_range(MAX_BURST, 127));
        return RCNT_W'($urandom_range(0, 127));
    endfunction

    // Work out the result words of one command and advance the model
    task automatic predict_command(t_cmd_code cmd, logic [BYTE_W-1:0] rx,
                                   logic [RCNT_W-1:0] want);
        t_result_word w;
        int           n;
        w = '0;
        case (cmd)
            CMD_PUSH: begin
                w.break_seen = (ring_last_stored == ring_break_char) &&
                               (rx == ring_break_char);
                if (ring_count < DEPTH) begin
                    ring_last_stored = rx;
                    ring_bytes[ring_wr_ptr] = rx;
                    ring_wr_ptr = (ring_wr_ptr + 1) % DEPTH;
                    ring_count++;
                    w.accepted = 1'b1;
                end
                w.is_last = 1'b1;
                w.fill = FILL_W'(ring_count);
                pending_results.push_back(w);
            end
            CMD_READ: begin
                n = want;
                if (n > MAX_BURST) n = MAX_BURST;
                if (n > ring_count) n = ring_count;
                if (n == 0) begin
                    w.is_last = 1'b1;
                    w.fill = FILL_W'(ring_count);
                    pending_results.push_back(w);
                end
                for (int i = 0; i < n; i++) begin
                    w.data_byte = ring_bytes[ring_rd_ptr];
                    w.data_valid = 1'b1;
                    ring_rd_ptr = (ring_rd_ptr + 1) % DEPTH;
                    ring_count--;
                    w.is_last = (i == n - 1);
                    w.fill = FILL_W'(ring_count);
                    pending_results.push_back(w);
                end
            end
            CMD_CLEAR: begin
                ring_wr_ptr = 0;
                ring_rd_ptr = 0;
                ring_count = 0;
                w.is_last = 1'b1;
                pending_results.push_back(w);
            end
            default: begin
                w.is_last = 1'b1;
                w.fill = FILL_W'(ring_count);
                pending_results.push_back(w);
            end
        endcase
    endtask

    // Send one command word, then predict its results at the accept edge.
    // Valid stays high on return; the caller drives the next word or drops it.
    task automatic send_command(t_cmd_code cmd, logic [BYTE_W-1:0] rx,
                                logic [RCNT_W-1:0] want);
        int gap;
        bit taken;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid      <= 1'b0;
            i_command    <= CMD_W'($urandom_range(0, 3));
            i_rx_byte    <= BYTE_W'($urandom_range(0, 255));
            i_read_count <= RCNT_W'($urandom_range(0, 127));
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_rx_byte    <= rx;
        i_read_count <= want;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        predict_command(cmd, rx, want);
    endtask

    // Drop valid and wait until every predicted word has arrived
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the break character over APB, then read it back
    task automatic write_break_char(logic [BYTE_W-1:0] value);
        bit                done;
        logic [APB_DW-1:0] readback;
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BREAK_CHAR, 2'b00};
        pwdata  <= {APB_DW'($urandom) & ~APB_DW'(8'hff)} | APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end
        ring_break_char = value;
        // Turn the write into a read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = pready;
            readback = prdata;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[BYTE_W-1:0] !== value) begin
            $display("%0t ns: break_char readback expected %0d got %0d",
                     $realtime, value, readback[BYTE_W-1:0]);
            mismatch_count++;
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d got %0d", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    // Stall the result channel in random runs
    always @(posedge i_clk) begin
        if (rx_quiet) begin
            i_stall <= 1'b0;
            rx_holding = 1'b0;
            rx_run_left = 0;
        end else if (rx_run_left > 0) begin
            rx_run_left = rx_run_left - 1;
        end else if (rx_holding) begin
            i_stall <= 1'b0;
            rx_holding = 1'b0;
            rx_run_left = $urandom_range(0, 15);
        end else begin
            rx_run = pick_gap();
            if (rx_run > 0) begin
                i_stall <= 1'b1;
                rx_holding = 1'b1;
                rx_run_left = rx_run - 1;
            end
        end
    end

    // Compare each word taken at the coming edge with the oldest prediction
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got_word = '{o_data_byte, o_data_valid, o_last, o_accepted,
                         o_break_seen, o_fill_level};
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected word, expected none got %h",
                         $realtime, got_word);
                mismatch_count++;
            end else begin
                want_word = pending_results.pop_front();
                check_field("data_byte", want_word.data_byte, got_word.data_byte);
                check_field("data_valid", 8'(want_word.data_valid),
                            8'(got_word.data_valid));
                check_field("last", 8'(want_word.is_last), 8'(got_word.is_last));
                check_field("accepted", 8'(want_word.accepted),
                            8'(got_word.accepted));
                check_field("break_seen", 8'(want_word.break_seen),
                            8'(got_word.break_seen));
                check_field("fill_level", want_word.fill, got_word.fill);
            end
        end
    end

    // Double break with the reset break character, extreme bytes
    task automatic test_break_detect();
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_PUSH, 8'h00, '0);
        send_command(CMD_PUSH, 8'hff, '0);
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_PUSH, 8'd17, '0);
    endtask

    // Zero count, saturated count, empty buffer, unused command
    task automatic test_read_limits();
        send_command(CMD_READ, 8'h00, 7'd0);
        send_command(CMD_READ, 8'hff, 7'd1);
        send_command(CMD_READ, 8'h00, 7'd127);
        send_command(CMD_READ, 8'h00, 7'd5);
        send_command(CMD_NOP, 8'hff, 7'd127);
    endtask

    // Clear empties the ring but keeps the last stored byte
    task automatic test_clear_keeps_last();
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_PUSH, 8'd42, '0);
        send_command(CMD_NOP, 8'h00, 7'd0);
        send_command(CMD_CLEAR, 8'hff, 7'd64);
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_PUSH, 8'd17, '0);
        send_command(CMD_READ, 8'h00, 7'd64);
    endtask

    // Break characters at both ends of the range
    task automatic test_break_char_extremes();
        write_break_char(8'h00);
        send_command(CMD_PUSH, 8'h00, '0);
        send_command(CMD_PUSH, 8'h00, '0);
        write_break_char(8'hff);
        send_command(CMD_PUSH, 8'hff, '0);
        send_command(CMD_PUSH, 8'hff, '0);
        send_command(CMD_READ, 8'h00, 7'd65);
        wait_results_drained();
    endtask

    // Fill the ring, push past full with mostly break characters, then drain it
    task automatic test_full_buffer();
        write_break_char(BYTE_W'($urandom_range(1, 254)));
        send_command(CMD_CLEAR, 8'h00, '0);
        for (int i = 0; i < DEPTH; i++) begin
            send_command(CMD_PUSH, pick_rx_byte(), RCNT_W'($urandom_range(0, 127)));
        end
        for (int i = 0; i < 8; i++) begin
            send_command(CMD_PUSH, (i % 3 == 2) ? pick_rx_byte() : ring_break_char,
                         '0);
        end
        // Hold off until the ring has reported back
        wait_results_drained();
        send_command(CMD_READ, 8'h00, 7'd127);
        send_command(CMD_READ, 8'h00, 7'd64);
        send_command(CMD_READ, 8'h00, 7'd3);
        wait_results_drained();
    endtask

    // Random command mix
    task automatic run_mixed(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 58)
                send_command(CMD_PUSH, pick_rx_byte(), RCNT_W'($urandom_range(0, 127)));
            else if (r < 88)
                send_command(CMD_READ, BYTE_W'($urandom_range(0, 255)),
                             pick_read_count());
            else if (r < 94)
                send_command(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)),
                             RCNT_W'($urandom_range(0, 127)));
            else
                send_command(CMD_NOP, BYTE_W'($urandom_range(0, 255)),
                             RCNT_W'($urandom_range(0, 127)));
        end
    endtask

    // Random traffic with idling on both sides and a pause halfway
    task automatic test_mixed_traffic();
        write_break_char(BYTE_W'($urandom_range(0, 255)));
        run_mixed(105);
        wait_results_drained();
        run_mixed(105);
        wait_results_drained();
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_back_to_back();
        write_break_char(8'd17);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_mixed(60);
        wait_results_drained();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_PUSH;
        i_rx_byte      = '0;
        i_read_count   = '0;
        i_stall        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        ring_wr_ptr    = 0;
        ring_rd_ptr    = 0;
        ring_count     = 0;
        ring_last_stored = '0;
        ring_break_char  = BREAK_CHAR_RST;
        mismatch_count = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rx_run_left    = 0;
        rx_holding     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_break_detect();
        test_read_limits();
        test_clear_keeps_last();
        test_break_char_extremes();
        test_full_buffer();
        test_mixed_traffic();
        test_back_to_back();

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** uart_rx_ring_with_break_detect_unit: PASSED **");
        end else begin
            $display("** uart_rx_ring_with_break_detect_unit: FAILED **");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("** uart_rx_ring_with_break_detect_unit: FAILED **");
        $finish;
    end

endmodule

[uart_rx_ring_with_break_detect_unit.f]
src/uartrb_pkg.sv
src/uartrb_ctrl.sv
src/uartrb_dp.sv
src/uart_rx_ring_with_break_detect_unit.sv
bench/tb_uart_rx_ring_with_break_detect_unit.sv
